[hw/rtl/uvst_pkg.sv]
// shared types and constants for the unique value set table
package uvst_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned ACTION_W      = 2;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned COUNT_W       = 5;
    localparam int unsigned DEFAULT_DEPTH = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_VIEW   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_DUP      = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_COMPARE,
        CELL_APPEND,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  key;
        logic signed [DATA_W-1:0]  head;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_VIEW
    } t_state;

endpackage

[hw/rtl/uvst_if.sv]
// request and response channel interfaces
interface uvst_req_if import uvst_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface uvst_rsp_if import uvst_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] element_value;
    logic                     element_present;
    logic [COUNT_W-1:0]       entry_count;
    logic                     last;

    modport source (output valid, output status, output element_value,
                    output element_present, output entry_count, output last,
                    input ready);
    modport sink   (input valid, input status, input element_value,
                    input element_present, input entry_count, input last,
                    output ready);
endinterface

[hw/rtl/uvst_cell.sv]
// one table slot: holds a value, compares it and shifts it toward its neighbor
module uvst_cell import uvst_pkg::*; #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CW    = 5
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic [CW-1:0]            i_count,
    input  logic signed [DATA_W-1:0] i_right_val,
    input  logic                     i_found,
    output logic signed [DATA_W-1:0] o_val,
    output logic                     o_found
);

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic signed [DATA_W-1:0] r_val, n_val;
    logic                     r_hit, n_hit;
    logic                     live;

    assign live    = MY_INDEX < i_count;
    // match seen here or in any lower slot
    assign o_found = i_found | r_hit;
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        n_hit = r_hit;
        case (i_ctl.op)
            CELL_COMPARE: n_hit = live && (r_val == i_ctl.key);
            CELL_APPEND: begin
                if (MY_INDEX == i_count) n_val = i_ctl.key;
            end
            CELL_REMOVE: begin
                if (o_found) n_val = i_right_val;
            end
            CELL_ROTATE: begin
                if (MY_INDEX == i_count - 1'b1) n_val = i_ctl.head;
                else if (live)                  n_val = i_right_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_hit <= n_hit;
    end

endmodule

[hw/rtl/unique_value_set_table_unit.sv]
// top level of the unique value set table: control sequencer and row of cells
//
// holds up to TABLE_DEPTH distinct signed 32-bit values in insertion order
// i_req carries one request per transfer: action (view, add, remove) and value
// o_rsp carries results: status, element_value, element_present, entry_count,
// last; last marks the final result of a request
// add and remove: the request is taken in idle, then every cell compares its
// value with the key, then the row is updated and the result register loaded
// once it is free; no new request is taken until the sequencer is back in idle
// view: the request is taken, then one result per cycle while the receiver
// accepts, as the row rotates toward slot zero; after count rotations the
// order is restored; an empty table gives a single marked result with no element
// the result register sits between the sequencer and o_rsp, so the next
// request is taken while the previous result waits; when the receiver stalls
// the sequencer holds in its current step until the register frees up
// reset (synchronous, active low) empties the table and drops o_rsp.valid;
// slot contents are not cleared, only slots below the live count are read
module unique_value_set_table_unit import uvst_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uvst_req_if.sink  i_req,
    uvst_rsp_if.source o_rsp
);

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    // sequencer state
    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_idx, n_idx;
    t_action                  r_action;
    logic signed [DATA_W-1:0] r_key;

    // result register
    logic                     r_out_valid;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_elem, n_elem;
    logic                     r_present, n_present;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_last, n_last;
    logic                     out_load;
    logic                     can_load;

    // row of cells
    t_cell_ctl                cell_ctl;
    logic signed [DATA_W-1:0] cell_val [TABLE_DEPTH];
    logic                     found [TABLE_DEPTH+1];
    logic                     any_hit;

    assign i_req.ready = (r_state == S_IDLE);
    assign can_load    = !r_out_valid || o_rsp.ready;
    assign any_hit     = found[TABLE_DEPTH];
    assign found[0]    = 1'b0;

    // each cell takes from its upper neighbor on remove and rotate
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] right_val;
        if (g == TABLE_DEPTH - 1) begin : g_top
            assign right_val = cell_val[g];
        end else begin : g_mid
            assign right_val = cell_val[g+1];
        end
        uvst_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_count     (r_count),
            .i_right_val (right_val),
            .i_found     (found[g]),
            .o_val       (cell_val[g]),
            .o_found     (found[g+1])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        cell_ctl.op   = CELL_HOLD;
        cell_ctl.key  = r_key;
        cell_ctl.head = cell_val[0];
        out_load      = 1'b0;
        n_status      = ST_DONE;
        n_elem        = '0;
        n_present     = 1'b0;
        n_last        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_req.valid) begin
                    n_state = (t_action'(i_req.action) == ACT_VIEW) ? S_VIEW : S_CMP;
                end
            end
            S_CMP: begin
                // every live cell checks its value against the key
                cell_ctl.op = CELL_COMPARE;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (can_load) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    case (r_action)
                        ACT_ADD: begin
                            // full wins over duplicate
                            if (r_count == FULL_COUNT) begin
                                n_status = ST_FULL;
                            end else if (any_hit) begin
                                n_status = ST_DUP;
                            end else begin
                                cell_ctl.op = CELL_APPEND;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        ACT_REMOVE: begin
                            if (!any_hit) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                // slots at and above the match take their upper neighbor
                                cell_ctl.op = CELL_REMOVE;
                                n_count     = r_count - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_VIEW: begin
                if (can_load) begin
                    out_load = 1'b1;
                    if (r_count == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        // emit slot zero and rotate the live part of the row
                        cell_ctl.op = CELL_ROTATE;
                        n_elem      = cell_val[0];
                        n_present   = 1'b1;
                        n_last      = (CW'(r_idx) == r_count - 1'b1);
                        n_idx       = r_idx + 1'b1;
                        if (n_last) n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (out_load)         r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_action <= t_action'(i_req.action);
            r_key    <= i_req.value;
        end
        if (out_load) begin
            r_status    <= n_status;
            r_elem      <= n_elem;
            r_present   <= n_present;
            r_out_count <= COUNT_W'(n_count);
            r_last      <= n_last;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.element_value   = r_elem;
    assign o_rsp.element_present = r_present;
    assign o_rsp.entry_count     = r_out_count;
    assign o_rsp.last            = r_last;

endmodule
